>>> src/limit_order_book_matcher_core_macros.svh
// Assertion macros shared by the matcher RTL.
`ifndef LIMIT_ORDER_BOOK_MATCHER_CORE_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_CORE_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define LOBM_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
		else $error("lobm assertion failed");
// Condition in one cycle implies a condition in the next.
`define LOBM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("lobm assertion failed");
`else
`define LOBM_ASSERT(lbl, ck, rn, prop)
`define LOBM_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

>>> src/lobm_pkg.sv
// Types and codes shared by the order book matcher.
package lobm_pkg;

	// Result status codes.
	localparam logic [1:0] ST_FILLED    = 2'd0;
	localparam logic [1:0] ST_RESTED    = 2'd1;
	localparam logic [1:0] ST_POOL_FULL = 2'd2;
	localparam logic [1:0] ST_LVL_FULL  = 2'd3;

	// Book sides.
	localparam logic SIDE_BID = 1'b0;
	localparam logic SIDE_ASK = 1'b1;

	// Sequencer states, one-hot.
	typedef enum logic [14:0] {
		S_IDLE  = 15'h0001,
		S_M_CHK = 15'h0002,
		S_M_LVL = 15'h0004,
		S_M_SLT = 15'h0008,
		S_R_SRD = 15'h0010,
		S_R_CMP = 15'h0020,
		S_R_DEC = 15'h0040,
		S_R_POP = 15'h0080,
		S_R_LNK = 15'h0100,
		S_R_SHR = 15'h0200,
		S_R_SHW = 15'h0400,
		S_F_BID = 15'h0800,
		S_F_ASK = 15'h1000,
		S_F_END = 15'h2000,
		S_DONE  = 15'h4000
	} st_t;

endpackage

>>> src/limit_order_book_matcher_core.sv
// Price-time priority limit order book matcher with pool and level memories.
// One order request in, one result request out. After an order is accepted in the
// idle state, the sequencer looks at the opposite book and fills resting orders
// oldest first until quantity runs out or the best level does not cross. A
// remainder then scans the own-side levels for its price or insertion point and
// takes a slot decision. If it rests, a freed slot is reused before a fresh one,
// and the order joins an existing level or opens a new one by moving worse
// levels down. Every order ends with a snapshot of both best prices and the
// result load. The result load waits while the previous result has not been
// accepted. The rate is set by the single read port of the level memory and the
// slot memories, each with a registered read. A new order is taken while a
// result waits to be accepted. No clearing pass is needed after reset: unused
// pool slots are handed out from a fill count.
module limit_order_book_matcher_core #(
	parameter int POOL_SLOTS      = 1024,
	parameter int LEVELS_PER_SIDE = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// order_id[31:0], trader[63:32], limit_price[95:64], order_qty[127:96]
	input  logic [127:0] s_tdata,
	// is_sell[0]
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// filled_qty[31:0], rest_slot[41:32], best_bid[73:42], best_ask[105:74],
	// bid_levels[114:106], ask_levels[123:115], zero[127:124]
	output logic [127:0] m_tdata,
	// status[1:0]
	output logic [1:0]   m_tuser
);
	import lobm_pkg::*;

	`include "limit_order_book_matcher_core_macros.svh"

	localparam int SLOT_W = $clog2(POOL_SLOTS);
	localparam int LINK_W = SLOT_W + 1;
	localparam int LVL_W  = $clog2(LEVELS_PER_SIDE);
	localparam int CNT_W  = $clog2(LEVELS_PER_SIDE + 1);
	localparam int LA_W   = LVL_W + 1;
	localparam logic [LINK_W-1:0] LINK_NONE = {1'b1, {SLOT_W{1'b0}}};

	typedef struct packed {
		logic [31:0]       price;
		logic [SLOT_W-1:0] first;
		logic [SLOT_W-1:0] last;
	} lvl_t;

	// Logical level index to ring position.
	function automatic logic [LVL_W-1:0] ring_idx(input logic [LVL_W-1:0] b,
			input logic [CNT_W-1:0] i);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(b) + (CNT_W+1)'(i);
		if (sum >= (CNT_W+1)'(LEVELS_PER_SIDE))
			sum = sum - (CNT_W+1)'(LEVELS_PER_SIDE);
		return sum[LVL_W-1:0];
	endfunction

	// Memories.
	lvl_t              lvl_mem [2**LA_W];
	logic [31:0]       qty_mem [POOL_SLOTS];
	logic [LINK_W-1:0] link_mem [POOL_SLOTS];
	logic [96:0]       info_mem [POOL_SLOTS];

	lvl_t              lvl_rd_q;
	logic [31:0]       qty_rd_q;
	logic [LINK_W-1:0] link_rd_q;

	logic              lvl_we;
	logic [LA_W-1:0]   lvl_wa, lvl_ra;
	lvl_t              lvl_wd;
	logic [SLOT_W-1:0] slot_ra;
	logic              qty_we, link_we, info_we;
	logic [SLOT_W-1:0] qty_wa, link_wa;
	logic [31:0]       qty_wd;
	logic [LINK_W-1:0] link_wd;

	// Control and order registers.
	st_t               state_q;
	logic              side_q;
	logic [31:0]       oid_q, trd_q, price_q, qty_q, filled_q;
	logic [1:0]        status_q;
	logic [SLOT_W-1:0] slot_q;
	logic              found_q;
	logic [CNT_W-1:0]  pos_q, idx_q;
	lvl_t              lvl_q;
	logic [LVL_W-1:0]  bid_base_q, ask_base_q;
	logic [CNT_W-1:0]  bid_cnt_q, ask_cnt_q;
	logic              fl_has_q;
	logic [SLOT_W-1:0] fl_top_q;
	logic [SLOT_W:0]   fresh_q;
	logic [31:0]       best_bid_q, best_ask_q;
	logic              m_tvalid_q;
	logic [31:0]       o_filled_q, o_bid_q, o_ask_q;
	logic [1:0]        o_status_q;
	logic [9:0]        o_slot_q;
	logic [8:0]        o_bid_lv_q, o_ask_lv_q;

	// Side selection: a sell matches bids and rests on asks.
	logic              opp_side, own_side;
	logic [LVL_W-1:0]  opp_base, own_base;
	logic [CNT_W-1:0]  opp_cnt, own_cnt;
	assign opp_side = ~side_q;
	assign own_side = side_q;
	assign opp_base = side_q ? bid_base_q : ask_base_q;
	assign own_base = side_q ? ask_base_q : bid_base_q;
	assign opp_cnt  = side_q ? bid_cnt_q : ask_cnt_q;
	assign own_cnt  = side_q ? ask_cnt_q : bid_cnt_q;

	// Match step arithmetic.
	logic              crosses, beyond, freed, pool_full, own_full;
	logic [31:0]       take, rem;
	logic [SLOT_W-1:0] alloc_slot;
	logic [LINK_W-1:0] push_link;
	logic [LVL_W-1:0]  opp_base_inc;
	assign crosses    = side_q ? (price_q <= lvl_rd_q.price) : (price_q >= lvl_rd_q.price);
	assign beyond     = side_q ? (lvl_rd_q.price > price_q) : (lvl_rd_q.price < price_q);
	assign take       = (qty_q < qty_rd_q) ? qty_q : qty_rd_q;
	assign rem        = qty_rd_q - take;
	assign freed      = (rem == 32'd0);
	assign pool_full  = !fl_has_q && (fresh_q == (SLOT_W+1)'(POOL_SLOTS));
	assign own_full   = (own_cnt == CNT_W'(LEVELS_PER_SIDE));
	assign alloc_slot = fl_has_q ? fl_top_q : fresh_q[SLOT_W-1:0];
	assign push_link  = fl_has_q ? {1'b0, fl_top_q} : LINK_NONE;
	assign opp_base_inc = (opp_base == LVL_W'(LEVELS_PER_SIDE - 1)) ? '0 :
		LVL_W'(opp_base + 1'b1);

	// Memory port control.
	always_comb begin
		lvl_we  = 1'b0;
		lvl_wa  = '0;
		lvl_wd  = lvl_rd_q;
		lvl_ra  = '0;
		slot_ra = lvl_rd_q.first;
		qty_we  = 1'b0;
		qty_wa  = slot_q;
		qty_wd  = qty_q;
		link_we = 1'b0;
		link_wa = slot_q;
		link_wd = LINK_NONE;
		info_we = 1'b0;
		case (state_q)
			S_M_CHK: begin
				lvl_ra = {opp_side, opp_base};
			end
			S_M_SLT: begin
				qty_we = 1'b1;
				qty_wa = lvl_q.first;
				qty_wd = rem;
				if (freed) begin
					link_we = 1'b1;
					link_wa = lvl_q.first;
					link_wd = push_link;
					if (!link_rd_q[SLOT_W]) begin
						lvl_we = 1'b1;
						lvl_wa = {opp_side, opp_base};
						lvl_wd = '{price: lvl_q.price, first: link_rd_q[SLOT_W-1:0],
							last: lvl_q.last};
					end
				end
			end
			S_R_SRD: begin
				lvl_ra = {own_side, ring_idx(own_base, pos_q)};
			end
			S_R_DEC: begin
				slot_ra = alloc_slot;
				if (!pool_full && !(!found_q && own_full)) begin
					qty_we  = 1'b1;
					qty_wa  = alloc_slot;
					info_we = 1'b1;
					link_we = 1'b1;
					link_wa = alloc_slot;
					link_wd = LINK_NONE;
				end
			end
			S_R_LNK: begin
				link_we = 1'b1;
				link_wa = lvl_q.last;
				link_wd = {1'b0, slot_q};
				lvl_we  = 1'b1;
				lvl_wa  = {own_side, ring_idx(own_base, pos_q)};
				lvl_wd  = '{price: lvl_q.price, first: lvl_q.first, last: slot_q};
			end
			S_R_SHR: begin
				lvl_ra = {own_side, ring_idx(own_base, CNT_W'(idx_q - 1'b1))};
				if (idx_q <= pos_q) begin
					lvl_we = 1'b1;
					lvl_wa = {own_side, ring_idx(own_base, pos_q)};
					lvl_wd = '{price: price_q, first: slot_q, last: slot_q};
				end
			end
			S_R_SHW: begin
				lvl_we = 1'b1;
				lvl_wa = {own_side, ring_idx(own_base, idx_q)};
				lvl_wd = lvl_rd_q;
			end
			S_F_BID: begin
				lvl_ra = {SIDE_BID, bid_base_q};
			end
			S_F_ASK: begin
				lvl_ra = {SIDE_ASK, ask_base_q};
			end
			default: begin
			end
		endcase
	end

	// Level memory.
	always_ff @(posedge clk) begin
		if (lvl_we)
			lvl_mem[lvl_wa] <= lvl_wd;
		lvl_rd_q <= lvl_mem[lvl_ra];
	end

	// Pool slot memories.
	always_ff @(posedge clk) begin
		if (qty_we)
			qty_mem[qty_wa] <= qty_wd;
		if (link_we)
			link_mem[link_wa] <= link_wd;
		if (info_we)
			info_mem[qty_wa] <= {side_q, trd_q, oid_q, price_q};
		qty_rd_q  <= qty_mem[slot_ra];
		link_rd_q <= link_mem[slot_ra];
	end

	// Order sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			side_q     <= 1'b0;
			oid_q      <= '0;
			trd_q      <= '0;
			price_q    <= '0;
			qty_q      <= '0;
			filled_q   <= '0;
			status_q   <= ST_FILLED;
			slot_q     <= '0;
			found_q    <= 1'b0;
			pos_q      <= '0;
			idx_q      <= '0;
			lvl_q      <= '0;
			bid_base_q <= '0;
			ask_base_q <= '0;
			bid_cnt_q  <= '0;
			ask_cnt_q  <= '0;
			fl_has_q   <= 1'b0;
			fl_top_q   <= '0;
			fresh_q    <= '0;
			best_bid_q <= '0;
			best_ask_q <= '0;
			m_tvalid_q <= 1'b0;
			o_filled_q <= '0;
			o_bid_q    <= '0;
			o_ask_q    <= '0;
			o_status_q <= ST_FILLED;
			o_slot_q   <= '0;
			o_bid_lv_q <= '0;
			o_ask_lv_q <= '0;
		end else begin
			// A taken result clears the output unless the done state reloads it.
			if (m_tvalid_q && m_tready && (state_q != S_DONE))
				m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						oid_q    <= s_tdata[31:0];
						trd_q    <= s_tdata[63:32];
						price_q  <= s_tdata[95:64];
						qty_q    <= s_tdata[127:96];
						side_q   <= s_tuser;
						filled_q <= '0;
						status_q <= ST_FILLED;
						slot_q   <= '0;
						state_q  <= S_M_CHK;
					end
				end
				// Look at the best opposite level while quantity remains.
				S_M_CHK: begin
					pos_q <= '0;
					if (qty_q == 32'd0)
						state_q <= S_F_BID;
					else if (opp_cnt == '0)
						state_q <= S_R_SRD;
					else
						state_q <= S_M_LVL;
				end
				S_M_LVL: begin
					lvl_q <= lvl_rd_q;
					state_q <= crosses ? S_M_SLT : S_R_SRD;
				end
				// Fill against the oldest order; free it and drop the level if emptied.
				S_M_SLT: begin
					qty_q    <= qty_q - take;
					filled_q <= filled_q + take;
					if (freed) begin
						fl_has_q <= 1'b1;
						fl_top_q <= lvl_q.first;
						if (link_rd_q[SLOT_W]) begin
							if (side_q) begin
								bid_base_q <= opp_base_inc;
								bid_cnt_q  <= CNT_W'(bid_cnt_q - 1'b1);
							end else begin
								ask_base_q <= opp_base_inc;
								ask_cnt_q  <= CNT_W'(ask_cnt_q - 1'b1);
							end
						end
					end
					state_q <= S_M_CHK;
				end
				// Scan the own side for the price or its insertion point.
				S_R_SRD: begin
					if (pos_q < own_cnt) begin
						state_q <= S_R_CMP;
					end else begin
						found_q <= 1'b0;
						state_q <= S_R_DEC;
					end
				end
				S_R_CMP: begin
					lvl_q <= lvl_rd_q;
					if (lvl_rd_q.price == price_q) begin
						found_q <= 1'b1;
						state_q <= S_R_DEC;
					end else if (beyond) begin
						found_q <= 1'b0;
						state_q <= S_R_DEC;
					end else begin
						pos_q   <= CNT_W'(pos_q + 1'b1);
						state_q <= S_R_SRD;
					end
				end
				// Allocate a slot or give up on the remainder.
				S_R_DEC: begin
					idx_q <= own_cnt;
					if (pool_full) begin
						status_q <= ST_POOL_FULL;
						state_q  <= S_F_BID;
					end else if (!found_q && own_full) begin
						status_q <= ST_LVL_FULL;
						state_q  <= S_F_BID;
					end else begin
						slot_q   <= alloc_slot;
						status_q <= ST_RESTED;
						if (fl_has_q) begin
							state_q <= S_R_POP;
						end else begin
							fresh_q <= fresh_q + 1'b1;
							state_q <= found_q ? S_R_LNK : S_R_SHR;
						end
					end
				end
				S_R_POP: begin
					fl_has_q <= !link_rd_q[SLOT_W];
					fl_top_q <= link_rd_q[SLOT_W-1:0];
					state_q  <= found_q ? S_R_LNK : S_R_SHR;
				end
				S_R_LNK: begin
					state_q <= S_F_BID;
				end
				// Open a new level by moving worse levels one place down.
				S_R_SHR: begin
					if (idx_q <= pos_q) begin
						if (side_q)
							ask_cnt_q <= CNT_W'(ask_cnt_q + 1'b1);
						else
							bid_cnt_q <= CNT_W'(bid_cnt_q + 1'b1);
						state_q <= S_F_BID;
					end else begin
						state_q <= S_R_SHW;
					end
				end
				S_R_SHW: begin
					idx_q   <= CNT_W'(idx_q - 1'b1);
					state_q <= S_R_SHR;
				end
				// Snapshot of both best prices.
				S_F_BID: begin
					state_q <= S_F_ASK;
				end
				S_F_ASK: begin
					best_bid_q <= (bid_cnt_q != '0) ? lvl_rd_q.price : 32'd0;
					state_q    <= S_F_END;
				end
				S_F_END: begin
					best_ask_q <= (ask_cnt_q != '0) ? lvl_rd_q.price : 32'd0;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						o_filled_q <= filled_q;
						o_status_q <= status_q;
						o_slot_q   <= (status_q == ST_RESTED) ? 10'(32'(slot_q)) : 10'd0;
						o_bid_q    <= best_bid_q;
						o_ask_q    <= best_ask_q;
						o_bid_lv_q <= 9'(32'(bid_cnt_q));
						o_ask_lv_q <= 9'(32'(ask_cnt_q));
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = o_status_q;
	assign m_tdata  = {4'd0, o_ask_lv_q, o_bid_lv_q, o_ask_q, o_bid_q, o_slot_q, o_filled_q};

	`LOBM_ASSERT(a_cnt_range, clk, arst_n, (bid_cnt_q <= CNT_W'(LEVELS_PER_SIDE)) && (ask_cnt_q <= CNT_W'(LEVELS_PER_SIDE)))
	`LOBM_ASSERT(a_fresh_range, clk, arst_n, fresh_q <= (SLOT_W+1)'(POOL_SLOTS))
	`LOBM_ASSERT(a_link_found, clk, arst_n, (state_q != S_R_LNK) || found_q)
	`LOBM_ASSERT_NEXT(a_take_order, clk, arst_n, s_tvalid && s_tready, state_q == S_M_CHK)
	`LOBM_ASSERT_NEXT(a_fill_bound, clk, arst_n, state_q == S_M_SLT, filled_q >= $past(filled_q))

endmodule
